### rtl/tfb_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Shared job record, job kinds, frame constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package tfb_pkg;

   localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND    = 8'h5A;
   localparam logic [15:0] CRC_SEED       = 16'hFFFF;
   localparam logic [8:0]  CAPACITY_RESET = 9'd261;
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [2:0] STEP_HEADER_LAST  = 3'd3;
   localparam logic [2:0] STEP_START_LAST   = 3'd5;
   localparam logic [2:0] STEP_PAYLOAD_LAST = 3'd2;
   localparam logic [2:0] STEP_SINGLE       = 3'd0;

   typedef enum logic [1:0] {
      JOB_START,
      JOB_PAYLOAD,
      JOB_ERROR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   data;
      logic [7:0]   len;
      logic [15:0]  crc;
      logic         trailer;
   } job_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] e;
      logic [7:0] f;
      e = crc[7:0] ^ b;
      f = e ^ {e[3:0], 4'b0000};
      return {8'h00, crc[15:8]} ^ {f, 8'h00} ^ {5'b00000, f, 3'b000} ^ {12'h000, f[7:4]};
   endfunction

endpackage

### rtl/tfb_front.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder front end
// Accepts commands, checks capacity and framing, keeps the running CRC and
// hands one job per accepted word to the queue.
// ----------------------------------------------------------------------------
module tfb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   input  logic             req_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data,
   input  logic             queue_full,
   output logic             push,
   output tfb_pkg::job_type push_job
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  left_ff, left_in;
   logic        in_frame_ff, in_frame_in;
   logic [8:0]  capacity_ff, capacity_in;

   logic [7:0]  frame_type;
   logic [7:0]  payload_length;
   logic [7:0]  payload_byte;
   logic [15:0] crc_hdr;
   logic [15:0] crc_pay;
   logic [7:0]  left_dec;
   logic        too_big;

   assign frame_type     = req_tdata[7:0];
   assign payload_length = req_tdata[15:8];
   assign payload_byte   = req_tdata[23:16];

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign crc_hdr  = tfb_pkg::crc_byte(tfb_pkg::crc_byte(tfb_pkg::CRC_SEED, frame_type),
                                       payload_length);
   assign crc_pay  = tfb_pkg::crc_byte(crc_ff, payload_byte);
   assign left_dec = left_ff - 8'd1;
   assign too_big  = ({1'b0, payload_length} + tfb_pkg::FRAME_OVERHEAD) > capacity_ff;

   always_comb begin
      crc_in      = crc_ff;
      left_in     = left_ff;
      in_frame_in = in_frame_ff;
      capacity_in = capacity_ff;
      push_job.kind    = tfb_pkg::JOB_ERROR;
      push_job.data    = payload_byte;
      push_job.len     = payload_length;
      push_job.crc     = crc_pay;
      push_job.trailer = 1'b0;
      if (csr_valid) begin
         capacity_in = csr_data;
      end
      if (push) begin
         if (!req_tuser) begin
            if (too_big) begin
               in_frame_in = 1'b0;
               left_in     = 8'd0;
               crc_in      = tfb_pkg::CRC_SEED;
            end else begin
               push_job.kind    = tfb_pkg::JOB_START;
               push_job.data    = frame_type;
               push_job.crc     = crc_hdr;
               push_job.trailer = (payload_length == 8'd0);
               if (payload_length == 8'd0) begin
                  in_frame_in = 1'b0;
                  left_in     = 8'd0;
                  crc_in      = tfb_pkg::CRC_SEED;
               end else begin
                  in_frame_in = 1'b1;
                  left_in     = payload_length;
                  crc_in      = crc_hdr;
               end
            end
         end else if (in_frame_ff) begin
            push_job.kind    = tfb_pkg::JOB_PAYLOAD;
            push_job.trailer = (left_dec == 8'd0);
            if (left_dec == 8'd0) begin
               in_frame_in = 1'b0;
               left_in     = 8'd0;
               crc_in      = tfb_pkg::CRC_SEED;
            end else begin
               left_in = left_dec;
               crc_in  = crc_pay;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= tfb_pkg::CRC_SEED;
         left_ff     <= 8'd0;
         in_frame_ff <= 1'b0;
         capacity_ff <= tfb_pkg::CAPACITY_RESET;
      end else begin
         crc_ff      <= crc_in;
         left_ff     <= left_in;
         in_frame_ff <= in_frame_in;
         capacity_ff <= capacity_in;
      end
   end

endmodule

### rtl/tfb_queue.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module tfb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tfb_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output tfb_pkg::job_type head_job
);

   tfb_pkg::job_type entry_ff [tfb_pkg::QUEUE_DEPTH];

   logic [tfb_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tfb_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tfb_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (tfb_pkg::QUEUE_AW + 1)'(tfb_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/tfb_back.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder back end
// Expands each queued job into its wire bytes and holds them in the output
// register until they are taken.
// ----------------------------------------------------------------------------
module tfb_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tfb_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;

   logic       emit;
   logic [2:0] last_step;
   logic [7:0] next_byte;
   logic       next_last;
   logic       next_err;

   assign emit = head_valid & (~valid_ff | rsp_tready);
   assign pop  = emit & (step_ff == last_step);

   always_comb begin
      last_step = tfb_pkg::STEP_SINGLE;
      next_byte = 8'h00;
      next_last = 1'b0;
      next_err  = 1'b0;
      case (head_job.kind)
         tfb_pkg::JOB_START: begin
            last_step = head_job.trailer ? tfb_pkg::STEP_START_LAST : tfb_pkg::STEP_HEADER_LAST;
            case (step_ff)
               3'd0:    next_byte = tfb_pkg::SYNC_FIRST;
               3'd1:    next_byte = tfb_pkg::SYNC_SECOND;
               3'd2:    next_byte = head_job.data;
               3'd3:    next_byte = head_job.len;
               3'd4:    next_byte = head_job.crc[7:0];
               default: begin
                  next_byte = head_job.crc[15:8];
                  next_last = 1'b1;
               end
            endcase
         end
         tfb_pkg::JOB_PAYLOAD: begin
            last_step = head_job.trailer ? tfb_pkg::STEP_PAYLOAD_LAST : tfb_pkg::STEP_SINGLE;
            case (step_ff)
               3'd0:    next_byte = head_job.data;
               3'd1:    next_byte = head_job.crc[7:0];
               default: begin
                  next_byte = head_job.crc[15:8];
                  next_last = 1'b1;
               end
            endcase
         end
         default: begin
            next_last = 1'b1;
            next_err  = 1'b1;
         end
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = next_byte;
         last_in  = next_last;
         err_in   = next_err;
         step_in  = pop ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = err_ff;

endmodule

### rtl/telemetry_frame_builder_crc16_top.sv
// ----------------------------------------------------------------------------
// Telemetry frame builder with CRC-16 trailer
// An accepted word is written into the job queue, and its first byte is then
// registered in the output register. The back end sends one byte per cycle while
// the receiver is ready: a start word gives 4 bytes, or 6 with the trailer; a
// payload word 1 byte, or 3 with the trailer; an error 1. Input is taken every
// cycle while the four-entry job queue has room. Reset is synchronous: frame
// state cleared, capacity 261, queue and output empty.
module telemetry_frame_builder_crc16_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // frame_type, payload_length, payload_byte
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // error_flag
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);

   logic             queue_full;
   logic             push;
   tfb_pkg::job_type push_job;
   logic             pop;
   logic             head_valid;
   tfb_pkg::job_type head_job;

   tfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   tfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### bench/tfb_bench_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame builder bench package
// Request command codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package tfb_bench_pkg;

   typedef enum logic {
      CMD_START   = 1'b0,
      CMD_PAYLOAD = 1'b1
   } frame_cmd_type;

endpackage

### bench/telemetry_frame_builder_crc16_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame builder checker
// Watches the request, response and CSR channels, keeps its own copy of the
// framing state and capacity, works out the wire bytes each accepted request
// word should produce and compares every response word with the oldest one.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_crc16_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // frame_type, payload_length, payload_byte
   input  logic        req_tuser,   // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_byte
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,   // error_flag
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [8:0]  csr_data,
   output int          fail_count,
   output int          pending_words,
   output int          words_checked,
   output int          frames_closed,
   output int          error_words
);

   localparam logic [15:0] CRC_POLY_REFLECTED = 16'h8408;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       error_flag;
   } wire_word_type;

   wire_word_type wire_bytes_due[$];
   logic [15:0]   crc_acc;
   logic [7:0]    bytes_remaining;
   logic          frame_open;
   logic [8:0]    capacity;
   int            mismatches = 0;
   int            checked = 0;
   int            closed = 0;
   int            errored = 0;

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   task automatic queue_byte(input logic [7:0] b, input logic last, input logic err);
      wire_bytes_due.push_back({b, last, err});
   endtask

   task automatic queue_crc_trailer();
      queue_byte(crc_acc[7:0], 1'b0, 1'b0);
      queue_byte(crc_acc[15:8], 1'b1, 1'b0);
      frame_open      = 1'b0;
      bytes_remaining = '0;
      crc_acc         = tfb_pkg::CRC_SEED;
   endtask

   task automatic predict_wire_bytes(input logic cmd, input logic [7:0] ftype,
                                     input logic [7:0] len, input logic [7:0] pbyte);
      if (cmd == tfb_bench_pkg::CMD_START) begin
         if (int'(len) + int'(tfb_pkg::FRAME_OVERHEAD) > int'(capacity)) begin
            frame_open      = 1'b0;
            bytes_remaining = '0;
            crc_acc         = tfb_pkg::CRC_SEED;
            queue_byte(8'h00, 1'b1, 1'b1);
         end else begin
            queue_byte(tfb_pkg::SYNC_FIRST, 1'b0, 1'b0);
            queue_byte(tfb_pkg::SYNC_SECOND, 1'b0, 1'b0);
            queue_byte(ftype, 1'b0, 1'b0);
            queue_byte(len, 1'b0, 1'b0);
            crc_acc = crc16_next(crc16_next(tfb_pkg::CRC_SEED, ftype), len);
            if (len == 8'd0) begin
               queue_crc_trailer();
            end else begin
               frame_open      = 1'b1;
               bytes_remaining = len;
            end
         end
      end else if (!frame_open) begin
         queue_byte(8'h00, 1'b1, 1'b1);
      end else begin
         queue_byte(pbyte, 1'b0, 1'b0);
         crc_acc         = crc16_next(crc_acc, pbyte);
         bytes_remaining = bytes_remaining - 8'd1;
         if (bytes_remaining == 8'd0) begin
            queue_crc_trailer();
         end
      end
   endtask

   always @(posedge clock) begin : watch
      wire_word_type got;
      wire_word_type want;
      if (reset) begin
         crc_acc         = tfb_pkg::CRC_SEED;
         bytes_remaining = '0;
         frame_open      = 1'b0;
         capacity        = tfb_pkg::CAPACITY_RESET;
         wire_bytes_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            capacity = csr_data;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tlast, rsp_tuser};
            checked++;
            if (got.error_flag) begin
               errored++;
            end else if (got.frame_end) begin
               closed++;
            end
            if (wire_bytes_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected rsp word: byte %02h last %0b err %0b",
                        $time, got.out_byte, got.frame_end, got.error_flag);
            end else begin
               want = wire_bytes_due.pop_front();
               if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
                   got.error_flag !== want.error_flag) begin
                  mismatches++;
                  $display("%0t: rsp word mismatch: expected byte %02h last %0b err %0b,",
                           $time, want.out_byte, want.frame_end, want.error_flag);
                  $display("   got byte %02h last %0b err %0b",
                           got.out_byte, got.frame_end, got.error_flag);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_wire_bytes(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]);
         end
      end
      fail_count    <= mismatches;
      pending_words <= wire_bytes_due.size();
      words_checked <= checked;
      frames_closed <= closed;
      error_words   <= errored;
   end

endmodule

### bench/telemetry_frame_builder_crc16_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Telemetry frame builder testbench
// Drives start and payload words into the framer under a series of capacity
// settings: a directed run over the edge cases, then random well-formed frames
// mixed with stray, abandoned and oversized ones. Both channels idle at random
// and the receiver holds off once for long enough to back up the input.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_crc16_top_tb;

   localparam int IDLE_PERCENT = 10;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_WORDS  = 10;
   localparam int PHASES       = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_data;

   int fail_count;
   int pending_words;
   int words_checked;
   int frames_closed;
   int error_words;
   int words_sent = 0;
   int csr_writes = 0;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   logic [8:0] capacity_now;

   telemetry_frame_builder_crc16_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   telemetry_frame_builder_crc16_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .words_checked (words_checked),
      .frames_closed (frames_closed),
      .error_words   (error_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic send_word(input tfb_bench_pkg::frame_cmd_type cmd, input logic [7:0] ftype,
                            input logic [7:0] len, input logic [7:0] pbyte);
      if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pbyte, len, ftype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_frame(input logic [7:0] len, input int body);
      send_word(tfb_bench_pkg::CMD_START, 8'($urandom), len, 8'($urandom));
      for (int i = 0; i < body; i++) begin
         send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [8:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      capacity_now = value;
      csr_writes++;
   endtask

   initial begin : stimulus
      int room;
      int len;
      int pick;
      int phase_start;
      logic [8:0] value;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= tfb_bench_pkg::CMD_START;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      capacity_now = 9'd261;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edge cases at the reset capacity, then at narrow settings and at the widest, 511.
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
      send_word(tfb_bench_pkg::CMD_START, 8'hFF, 8'd0, 8'h00);
      send_word(tfb_bench_pkg::CMD_START, 8'h00, 8'd255, 8'hFF);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'hFF, 8'hFF, 8'h00);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
      send_word(tfb_bench_pkg::CMD_START, 8'hAA, 8'd2, 8'h00);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h55, 8'hAA, 8'h55);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'hAA, 8'h55, 8'hA5);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h3C, 8'hC3, 8'h5A);
      send_word(tfb_bench_pkg::CMD_START, 8'h81, 8'd1, 8'h7E);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h7E, 8'h81, 8'h80);
      write_capacity(9'd6);
      send_word(tfb_bench_pkg::CMD_START, 8'h01, 8'd0, 8'h00);
      send_word(tfb_bench_pkg::CMD_START, 8'h02, 8'd1, 8'h00);
      write_capacity(9'd10);
      send_word(tfb_bench_pkg::CMD_START, 8'h10, 8'd3, 8'h00);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h42);
      send_word(tfb_bench_pkg::CMD_START, 8'h11, 8'd5, 8'h00);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'h43);
      write_capacity(9'd0);
      send_word(tfb_bench_pkg::CMD_START, 8'h20, 8'd0, 8'h00);
      write_capacity(9'd5);
      send_word(tfb_bench_pkg::CMD_START, 8'h21, 8'd0, 8'h00);
      write_capacity(9'd511);
      send_word(tfb_bench_pkg::CMD_START, 8'hC0, 8'd255, 8'h00);
      send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'h00, 8'h00, 8'hEE);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: value = 9'd261;
            1: value = 9'd6;
            2: value = 9'($urandom_range(7, 40));
            3: value = 9'd261;
            4: value = 9'($urandom_range(6, 261));
            default: value = 9'($urandom_range(0, 511));
         endcase
         write_capacity(value);
         quiet = (phase == 2);
         room = (capacity_now >= 9'd6) ? int'(capacity_now) - 6 : 0;
         if (room > 40) begin
            room = 40;
         end
         if (phase == 3) begin
            hold_request = 1'b1;
            send_frame(8'd12, 12);
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 40);
               if (len > room) begin
                  len = room;
               end
               send_frame(8'(len), len);
            end else if (pick < 80) begin
               len = $urandom_range(1, 8);
               send_frame(8'(len), $urandom_range(0, len - 1));
            end else if (pick < 90) begin
               send_word(tfb_bench_pkg::CMD_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               send_word(tfb_bench_pkg::CMD_START, 8'($urandom), 8'($urandom_range(0, 255)),
                         8'($urandom));
            end
         end
      end
      quiet = 1'b0;

      wait_drained();
      $display("tb: %0d request words under %0d capacity settings, %0d response words checked",
               words_sent, csr_writes, words_checked);
      $display("tb: %0d frames closed with a CRC trailer, %0d error words",
               frames_closed, error_words);
      if (fail_count == 0 && pending_words == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
rtl/tfb_pkg.sv
rtl/tfb_front.sv
rtl/tfb_queue.sv
rtl/tfb_back.sv
rtl/telemetry_frame_builder_crc16_top.sv
bench/tfb_bench_pkg.sv
bench/telemetry_frame_builder_crc16_checker.sv
bench/telemetry_frame_builder_crc16_top_tb.sv
